### design/image_raw_moments_accumulator_defines.svh
// ----------------------------------------------------------------------------
// Raw moments accumulator assertion macros
// Shared check forms for the accumulator top level.
// ----------------------------------------------------------------------------
`ifndef IMAGE_RAW_MOMENTS_ACCUMULATOR_DEFINES_SVH
`define IMAGE_RAW_MOMENTS_ACCUMULATOR_DEFINES_SVH

// check a consequent in the same cycle as its antecedent
`define RMOM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// check a consequent in the cycle after its antecedent
`define RMOM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### design/rmom_pkg.sv
// ----------------------------------------------------------------------------
// Raw moments accumulator package
// Field widths, register and mode codes, and queue flag type.
// ----------------------------------------------------------------------------
package rmom_pkg;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam int CFG_DIM_W   = 13;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_INDEX_W = 2;
    localparam int LABEL_W     = 8;
    localparam int MODE_W      = 2;
    localparam int VALUE_W     = 8;

    localparam int COUNT_W  = 25;
    localparam int WEIGHT_W = 32;
    localparam int SUM1_W   = 44;
    localparam int SUM2_W   = 56;

    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_TARGET_LABEL = 2'd2,
        REG_SOURCE_MODE  = 2'd3
    } t_reg;

    typedef enum logic [MODE_W-1:0] {
        MODE_PIXELS = 2'd0,
        MODE_MASK   = 2'd1,
        MODE_GATED  = 2'd2
    } t_mode;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_flags;

endpackage

### design/rmom_front.sv
// ----------------------------------------------------------------------------
// Raw moments front end
// Holds configuration, tracks raster position and derives count and weight.
// ----------------------------------------------------------------------------
module rmom_front import rmom_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
    localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
    localparam int IW = XW + YW + VALUE_W + 2
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_in_valid,
    input  logic [VALUE_W-1:0]     i_pixel_value,
    input  logic [LABEL_W-1:0]     i_mask_label,
    input  t_q_flags               i_q_flags,
    output logic                   o_push,
    output logic [IW-1:0]          o_item
);

    localparam int XCW = (XW + 1 > CFG_DIM_W) ? XW + 1 : CFG_DIM_W;
    localparam int YCW = (YW + 1 > CFG_DIM_W) ? YW + 1 : CFG_DIM_W;

    logic [CFG_DIM_W-1:0] r_width;
    logic [CFG_DIM_W-1:0] r_height;
    logic [LABEL_W-1:0]   r_label;
    t_mode                r_mode;
    logic [XW-1:0]        r_col;
    logic [YW-1:0]        r_row;
    logic [XW-1:0]        n_col;
    logic [YW-1:0]        n_row;

    logic [XCW-1:0]     w_eff;
    logic [YCW-1:0]     h_eff;
    logic               last_col;
    logic               last_row;
    logic               match;
    logic               cnt;
    logic [VALUE_W-1:0] wgt;

    always_comb begin
        if (r_width == '0) begin
            w_eff = XCW'(1);
        end else if (XCW'(r_width) > XCW'(MAX_WIDTH)) begin
            w_eff = XCW'(MAX_WIDTH);
        end else begin
            w_eff = XCW'(r_width);
        end
        if (r_height == '0) begin
            h_eff = YCW'(1);
        end else if (YCW'(r_height) > YCW'(MAX_HEIGHT)) begin
            h_eff = YCW'(MAX_HEIGHT);
        end else begin
            h_eff = YCW'(r_height);
        end
    end

    assign last_col = (XCW'(r_col) + XCW'(1)) >= w_eff;
    assign last_row = (YCW'(r_row) + YCW'(1)) >= h_eff;
    assign match    = (i_mask_label == r_label);

    always_comb begin
        unique case (r_mode)
            MODE_PIXELS: begin
                cnt = 1'b1;
                wgt = i_pixel_value;
            end
            MODE_MASK: begin
                cnt = match;
                wgt = VALUE_W'(match);
            end
            default: begin
                cnt = match;
                wgt = match ? i_pixel_value : '0;
            end
        endcase
    end

    assign o_push = i_in_valid && !i_q_flags.full;
    assign o_item = {last_col && last_row, cnt, wgt, r_row, r_col};

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (o_push) begin
            if (last_col && last_row) begin
                n_col = '0;
                n_row = '0;
            end else if (last_col) begin
                n_col = '0;
                n_row = r_row + YW'(1);
            end else begin
                n_col = r_col + XW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= CFG_DIM_W'(1);
            r_height <= CFG_DIM_W'(1);
            r_label  <= '0;
            r_mode   <= MODE_PIXELS;
            r_col    <= '0;
            r_row    <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (i_cfg_valid) begin
                unique case (t_reg'(i_cfg_index))
                    REG_FRAME_WIDTH:  r_width  <= i_cfg_data;
                    REG_FRAME_HEIGHT: r_height <= i_cfg_data;
                    REG_TARGET_LABEL: r_label  <= i_cfg_data[LABEL_W-1:0];
                    REG_SOURCE_MODE:  r_mode   <= t_mode'(i_cfg_data[MODE_W-1:0]);
                endcase
            end
        end
    end

endmodule

### design/rmom_queue.sv
// ----------------------------------------------------------------------------
// Raw moments item queue
// Short first-in first-out buffer between front end and accumulator.
// ----------------------------------------------------------------------------
module rmom_queue import rmom_pkg::*; #(
    parameter int W = 1
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_item,
    input  logic         i_pop,
    output logic [W-1:0] o_head,
    output t_q_flags     o_flags
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    logic [W-1:0] r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [PW:0]   r_count;

    assign o_head        = r_mem[r_rd_ptr];
    assign o_flags.full  = (r_count == (PW+1)'(QUEUE_DEPTH));
    assign o_flags.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (PW+1)'(1);
                2'b01:   r_count <= r_count - (PW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### design/rmom_back.sv
// ----------------------------------------------------------------------------
// Raw moments accumulator back end
// Two product stages, the seven sums and the result register.
// ----------------------------------------------------------------------------
module rmom_back import rmom_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
    localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
    localparam int IW = XW + YW + VALUE_W + 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [IW-1:0]       i_head,
    input  t_q_flags            i_q_flags,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [COUNT_W-1:0]  o_pixel_count,
    output logic [WEIGHT_W-1:0] o_weight_sum,
    output logic [SUM1_W-1:0]   o_sum_x,
    output logic [SUM1_W-1:0]   o_sum_y,
    output logic [SUM2_W-1:0]   o_sum_xx,
    output logic [SUM2_W-1:0]   o_sum_xy,
    output logic [SUM2_W-1:0]   o_sum_yy
);

    localparam int WXW  = VALUE_W + XW;
    localparam int WYW  = VALUE_W + YW;
    localparam int WXXW = WXW + XW;
    localparam int WXYW = WXW + YW;
    localparam int WYYW = WYW + YW;

    logic [XW-1:0]      h_x;
    logic [YW-1:0]      h_y;
    logic [VALUE_W-1:0] h_w;
    logic               h_c;
    logic               h_last;
    logic               adv;

    logic               r_p1_valid;
    logic               r_p1_last;
    logic               r_p1_c;
    logic [VALUE_W-1:0] r_p1_w;
    logic [XW-1:0]      r_p1_x;
    logic [YW-1:0]      r_p1_y;
    logic [WXW-1:0]     r_p1_wx;
    logic [WYW-1:0]     r_p1_wy;

    logic               r_p2_valid;
    logic               r_p2_last;
    logic               r_p2_c;
    logic [VALUE_W-1:0] r_p2_w;
    logic [WXW-1:0]     r_p2_wx;
    logic [WYW-1:0]     r_p2_wy;
    logic [WXXW-1:0]    r_p2_wxx;
    logic [WXYW-1:0]    r_p2_wxy;
    logic [WYYW-1:0]    r_p2_wyy;

    logic [COUNT_W-1:0]  r_n_acc;
    logic [WEIGHT_W-1:0] r_s_acc;
    logic [SUM1_W-1:0]   r_x_acc;
    logic [SUM1_W-1:0]   r_y_acc;
    logic [SUM2_W-1:0]   r_xx_acc;
    logic [SUM2_W-1:0]   r_xy_acc;
    logic [SUM2_W-1:0]   r_yy_acc;

    logic [COUNT_W-1:0]  n_n_acc;
    logic [WEIGHT_W-1:0] n_s_acc;
    logic [SUM1_W-1:0]   n_x_acc;
    logic [SUM1_W-1:0]   n_y_acc;
    logic [SUM2_W-1:0]   n_xx_acc;
    logic [SUM2_W-1:0]   n_xy_acc;
    logic [SUM2_W-1:0]   n_yy_acc;

    logic r_out_valid;

    assign {h_last, h_c, h_w, h_y, h_x} = i_head;

    assign adv         = !(r_out_valid && i_out_stall);
    assign o_pop       = adv && !i_q_flags.empty;
    assign o_out_valid = r_out_valid;

    assign n_n_acc  = r_n_acc + COUNT_W'(r_p2_c);
    assign n_s_acc  = r_s_acc + WEIGHT_W'(r_p2_w);
    assign n_x_acc  = r_x_acc + SUM1_W'(r_p2_wx);
    assign n_y_acc  = r_y_acc + SUM1_W'(r_p2_wy);
    assign n_xx_acc = r_xx_acc + SUM2_W'(r_p2_wxx);
    assign n_xy_acc = r_xy_acc + SUM2_W'(r_p2_wxy);
    assign n_yy_acc = r_yy_acc + SUM2_W'(r_p2_wyy);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p1_last <= h_last;
            r_p1_c    <= h_c;
            r_p1_w    <= h_w;
            r_p1_x    <= h_x;
            r_p1_y    <= h_y;
            r_p1_wx   <= WXW'(h_w) * WXW'(h_x);
            r_p1_wy   <= WYW'(h_w) * WYW'(h_y);
            r_p2_last <= r_p1_last;
            r_p2_c    <= r_p1_c;
            r_p2_w    <= r_p1_w;
            r_p2_wx   <= r_p1_wx;
            r_p2_wy   <= r_p1_wy;
            r_p2_wxx  <= WXXW'(r_p1_wx) * WXXW'(r_p1_x);
            r_p2_wxy  <= WXYW'(r_p1_wx) * WXYW'(r_p1_y);
            r_p2_wyy  <= WYYW'(r_p1_wy) * WYYW'(r_p1_y);
            if (r_p2_valid && r_p2_last) begin
                o_pixel_count <= n_n_acc;
                o_weight_sum  <= n_s_acc;
                o_sum_x       <= n_x_acc;
                o_sum_y       <= n_y_acc;
                o_sum_xx      <= n_xx_acc;
                o_sum_xy      <= n_xy_acc;
                o_sum_yy      <= n_yy_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid  <= 1'b0;
            r_p2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_n_acc     <= '0;
            r_s_acc     <= '0;
            r_x_acc     <= '0;
            r_y_acc     <= '0;
            r_xx_acc    <= '0;
            r_xy_acc    <= '0;
            r_yy_acc    <= '0;
        end else if (adv) begin
            r_p1_valid  <= !i_q_flags.empty;
            r_p2_valid  <= r_p1_valid;
            r_out_valid <= r_p2_valid && r_p2_last;
            if (r_p2_valid) begin
                if (r_p2_last) begin
                    r_n_acc  <= '0;
                    r_s_acc  <= '0;
                    r_x_acc  <= '0;
                    r_y_acc  <= '0;
                    r_xx_acc <= '0;
                    r_xy_acc <= '0;
                    r_yy_acc <= '0;
                end else begin
                    r_n_acc  <= n_n_acc;
                    r_s_acc  <= n_s_acc;
                    r_x_acc  <= n_x_acc;
                    r_y_acc  <= n_y_acc;
                    r_xx_acc <= n_xx_acc;
                    r_xy_acc <= n_xy_acc;
                    r_yy_acc <= n_yy_acc;
                end
            end
        end
    end

endmodule

### design/image_raw_moments_accumulator.sv
// ----------------------------------------------------------------------------
// Image raw moments accumulator
// Takes one pixel per word in raster order and, on the last pixel of each
// frame, returns the count and the raw moments of order up to two. Pixels are
// taken at one per clock while the four-entry queue has room; after the last
// pixel of a frame is taken, it passes through the queue and the two multiply
// stages into the result register. A stalled result holds the accumulator
// pipeline, and the queue then fills and stalls the input. Configuration is
// taken every cycle and acts on the next pixel.
// ----------------------------------------------------------------------------
`include "image_raw_moments_accumulator_defines.svh"

module image_raw_moments_accumulator import rmom_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [VALUE_W-1:0]     i_pixel_value,
    input  logic [LABEL_W-1:0]     i_mask_label,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [COUNT_W-1:0]     o_pixel_count,
    output logic [WEIGHT_W-1:0]    o_weight_sum,
    output logic [SUM1_W-1:0]      o_sum_x,
    output logic [SUM1_W-1:0]      o_sum_y,
    output logic [SUM2_W-1:0]      o_sum_xx,
    output logic [SUM2_W-1:0]      o_sum_xy,
    output logic [SUM2_W-1:0]      o_sum_yy
);

    localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int IW = XW + YW + VALUE_W + 2;

    logic          push;
    logic          pop;
    logic [IW-1:0] item;
    logic [IW-1:0] head;
    t_q_flags      q_flags;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = q_flags.full;

    rmom_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid && o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .i_pixel_value (i_pixel_value),
        .i_mask_label  (i_mask_label),
        .i_q_flags     (q_flags),
        .o_push        (push),
        .o_item        (item)
    );

    rmom_queue #(
        .W (IW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (item),
        .i_pop   (pop),
        .o_head  (head),
        .o_flags (q_flags)
    );

    rmom_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .i_q_flags     (q_flags),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_pixel_count (o_pixel_count),
        .o_weight_sum  (o_weight_sum),
        .o_sum_x       (o_sum_x),
        .o_sum_y       (o_sum_y),
        .o_sum_xx      (o_sum_xx),
        .o_sum_xy      (o_sum_xy),
        .o_sum_yy      (o_sum_yy)
    );

    `RMOM_ASSERT_NOW(a_pop_not_empty, pop, !q_flags.empty, "pop from empty queue")
    `RMOM_ASSERT_NOW(a_push_not_full, push, !q_flags.full, "push into full queue")
    `RMOM_ASSERT_NOW(a_hold_on_stall, o_out_valid && i_out_stall, !pop,
        "queue drained while result is held")
    `RMOM_ASSERT_NEXT(a_queue_gains, push && !pop, !q_flags.empty,
        "queue empty after a push")

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// Raw moments accumulator testbench
// Streams pixel words through the accumulator under random input gaps and
// output stalls. A local model tracks the frame position and the seven sums
// and queues the expected moments for every completed frame. Each returned
// word is checked field by field against the oldest entry in that queue.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rmom_pkg::*;

    localparam int SETTLE_CYCLES = 12;
    localparam int RANDOM_PIXELS = 1000;
    localparam int EXTREME_RUN   = 60;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'b11;

    typedef struct {
        logic [COUNT_W-1:0]  count;
        logic [WEIGHT_W-1:0] weight;
        logic [SUM1_W-1:0]   sx;
        logic [SUM1_W-1:0]   sy;
        logic [SUM2_W-1:0]   sxx;
        logic [SUM2_W-1:0]   sxy;
        logic [SUM2_W-1:0]   syy;
    } t_moments;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_valid   = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;
    logic                   i_in_valid    = 1'b0;
    logic [VALUE_W-1:0]     i_pixel_value = '0;
    logic [LABEL_W-1:0]     i_mask_label  = '0;
    logic                   i_out_stall   = 1'b0;
    logic                   o_cfg_ready;
    logic                   o_in_stall;
    logic                   o_out_valid;
    logic [COUNT_W-1:0]     o_pixel_count;
    logic [WEIGHT_W-1:0]    o_weight_sum;
    logic [SUM1_W-1:0]      o_sum_x;
    logic [SUM1_W-1:0]      o_sum_y;
    logic [SUM2_W-1:0]      o_sum_xx;
    logic [SUM2_W-1:0]      o_sum_xy;
    logic [SUM2_W-1:0]      o_sum_yy;

    image_raw_moments_accumulator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_pixel_value (i_pixel_value),
        .i_mask_label  (i_mask_label),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_pixel_count (o_pixel_count),
        .o_weight_sum  (o_weight_sum),
        .o_sum_x       (o_sum_x),
        .o_sum_y       (o_sum_y),
        .o_sum_xx      (o_sum_xx),
        .o_sum_xy      (o_sum_xy),
        .o_sum_yy      (o_sum_yy)
    );

    always #4 i_clk = ~i_clk;

    logic [CFG_DIM_W-1:0] shadow_width;
    logic [CFG_DIM_W-1:0] shadow_height;
    logic [LABEL_W-1:0]   shadow_label;
    logic [MODE_W-1:0]    shadow_mode;
    int unsigned          frame_col;
    int unsigned          frame_row;
    t_moments             frame_acc;
    t_moments             pending_moments[$];

    int fails      = 0;
    int gap_max    = 0;
    int stall_pct  = 0;
    int hold_req   = 0;
    int burst_left = 0;

    function automatic int unsigned clamp_dim(logic [CFG_DIM_W-1:0] v, int unsigned maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function automatic void clear_frame();
        frame_col = 0;
        frame_row = 0;
        frame_acc = '{default: '0};
    endfunction

    task automatic accumulate_pixel(input logic [VALUE_W-1:0] v, input logic [LABEL_W-1:0] l);
        logic [63:0] cnt;
        logic [63:0] wt;
        logic [63:0] x;
        logic [63:0] y;
        logic        hit;
        int unsigned w_eff;
        int unsigned h_eff;
        hit = (l == shadow_label);
        case (shadow_mode)
            MODE_PIXELS: begin
                cnt = 64'd1;
                wt  = 64'(v);
            end
            MODE_MASK: begin
                cnt = 64'(hit);
                wt  = 64'(hit);
            end
            default: begin
                cnt = 64'(hit);
                wt  = hit ? 64'(v) : 64'd0;
            end
        endcase
        x = frame_col;
        y = frame_row;
        frame_acc.count  = frame_acc.count + COUNT_W'(cnt);
        frame_acc.weight = frame_acc.weight + WEIGHT_W'(wt);
        frame_acc.sx     = frame_acc.sx + SUM1_W'(wt * x);
        frame_acc.sy     = frame_acc.sy + SUM1_W'(wt * y);
        frame_acc.sxx    = frame_acc.sxx + SUM2_W'(wt * x * x);
        frame_acc.sxy    = frame_acc.sxy + SUM2_W'(wt * x * y);
        frame_acc.syy    = frame_acc.syy + SUM2_W'(wt * y * y);
        w_eff = clamp_dim(shadow_width, DEF_MAX_WIDTH);
        h_eff = clamp_dim(shadow_height, DEF_MAX_HEIGHT);
        if (frame_col + 1 >= w_eff && frame_row + 1 >= h_eff) begin
            pending_moments.push_back(frame_acc);
            clear_frame();
        end else if (frame_col + 1 >= w_eff) begin
            frame_col = 0;
            frame_row = frame_row + 1;
        end else begin
            frame_col = frame_col + 1;
        end
    endtask

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        fails++;
        if (fails <= 40)
            $display("ERROR %0t %s: got %0d, expected %0d", $time, field, got, want);
    endtask

    // track configuration and accepted pixels
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            shadow_width  = 1;
            shadow_height = 1;
            shadow_label  = '0;
            shadow_mode   = MODE_PIXELS;
            clear_frame();
        end else begin
            if (i_in_valid && !o_in_stall)
                accumulate_pixel(i_pixel_value, i_mask_label);
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_reg'(i_cfg_index))
                    REG_FRAME_WIDTH:  shadow_width  = i_cfg_data;
                    REG_FRAME_HEIGHT: shadow_height = i_cfg_data;
                    REG_TARGET_LABEL: shadow_label  = i_cfg_data[LABEL_W-1:0];
                    REG_SOURCE_MODE:  shadow_mode   = i_cfg_data[MODE_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        t_moments want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_moments.size() == 0) begin
                report_mismatch("unexpected word, pixel_count", o_pixel_count, 0);
            end else begin
                want = pending_moments.pop_front();
                if (o_pixel_count !== want.count)
                    report_mismatch("pixel_count", o_pixel_count, want.count);
                if (o_weight_sum !== want.weight)
                    report_mismatch("weight_sum", o_weight_sum, want.weight);
                if (o_sum_x !== want.sx)
                    report_mismatch("sum_x", o_sum_x, want.sx);
                if (o_sum_y !== want.sy)
                    report_mismatch("sum_y", o_sum_y, want.sy);
                if (o_sum_xx !== want.sxx)
                    report_mismatch("sum_xx", o_sum_xx, want.sxx);
                if (o_sum_xy !== want.sxy)
                    report_mismatch("sum_xy", o_sum_xy, want.sxy);
                if (o_sum_yy !== want.syy)
                    report_mismatch("sum_yy", o_sum_yy, want.syy);
            end
        end
    end

    // receiver stall pattern, with an occasional long hold
    initial begin
        int   run;
        int   n;
        logic level;
        forever begin
            if (hold_req > 0) begin
                n = hold_req;
                hold_req = 0;
                repeat (n) begin
                    i_out_stall <= 1'b1;
                    @(posedge i_clk);
                end
            end else begin
                run   = $urandom_range(1, 8);
                level = ($urandom_range(0, 99) < stall_pct);
                repeat (run) begin
                    i_out_stall <= level;
                    @(posedge i_clk);
                end
            end
        end
    end

    initial begin
        #5ms;
        $display("image_raw_moments_accumulator: mismatch");
        $finish;
    end

    task automatic put_pixel(input logic [VALUE_W-1:0] v, input logic [LABEL_W-1:0] l);
        i_in_valid    <= 1'b1;
        i_pixel_value <= v;
        i_mask_label  <= l;
        do @(posedge i_clk); while (o_in_stall);
        if (gap_max > 0) begin
            if (burst_left == 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, gap_max)) @(posedge i_clk);
                burst_left = $urandom_range(1, 16);
            end else begin
                burst_left--;
            end
        end
    endtask

    // hold input until all frames are back and the pipeline is empty
    task automatic settle_block();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_moments.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_reg idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic setup_frame(input logic [CFG_DATA_W-1:0] width_data,
                               input logic [CFG_DATA_W-1:0] height_data,
                               input logic [CFG_DATA_W-1:0] label_data,
                               input logic [CFG_DATA_W-1:0] mode_data);
        settle_block();
        cfg_write(REG_FRAME_WIDTH, width_data);
        cfg_write(REG_FRAME_HEIGHT, height_data);
        cfg_write(REG_TARGET_LABEL, label_data);
        cfg_write(REG_SOURCE_MODE, mode_data);
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return VALUE_W'($urandom);
    endfunction

    task automatic test_reset_defaults();
        put_pixel(8'hFF, 8'h00);
        put_pixel(8'h00, 8'hFF);
    endtask

    task automatic test_source_modes();
        logic [LABEL_W-1:0]    targets[4];
        logic [CFG_DATA_W-1:0] modes[4];
        targets = '{8'hA5, 8'h00, 8'hFF, 8'h5A};
        modes   = '{{11'h7FF, MODE_PIXELS}, {11'h000, MODE_MASK},
                    {11'h2AA, MODE_GATED}, {11'h7FF, MODE_UNUSED}};
        gap_max   = 3;
        stall_pct = 40;
        for (int i = 0; i < 4; i++) begin
            setup_frame(2, 2, {5'h1F, targets[i]}, modes[i]);
            put_pixel(8'hFF, targets[i]);
            put_pixel(8'h00, targets[i]);
            put_pixel(8'hFF, ~targets[i]);
            put_pixel(VALUE_W'($urandom_range(1, 254)), targets[i]);
        end
    endtask

    // a zero width or height acts as one
    task automatic test_empty_frame_size();
        setup_frame(0, 0, 13'h003C, {11'h000, MODE_GATED});
        put_pixel(8'd200, 8'h3C);
        put_pixel(8'd200, 8'h3D);
    endtask

    task automatic test_mid_frame_resize();
        setup_frame(13'h1FFF, 13'h1FFF, 13'h0000, {11'h000, MODE_PIXELS});
        repeat (3) put_pixel(pick_value(), 8'h00);
        settle_block();
        cfg_write(REG_FRAME_WIDTH, 2);
        repeat (2) put_pixel(pick_value(), 8'h00);
        settle_block();
        cfg_write(REG_FRAME_HEIGHT, 1);
        put_pixel(pick_value(), 8'h00);
    endtask

    task automatic test_back_pressure();
        setup_frame(1, 1, 13'h0000, {11'h000, MODE_PIXELS});
        gap_max  = 0;
        hold_req = 80;
        repeat (40) put_pixel(VALUE_W'($urandom), LABEL_W'($urandom));
        settle_block();
    endtask

    // oversize frames, ended early by shrinking the frame
    task automatic test_extreme_frames();
        gap_max   = 0;
        stall_pct = 20;
        setup_frame(13'h1FFF, 1, 13'h0000, {11'h000, MODE_PIXELS});
        repeat (EXTREME_RUN) put_pixel(($urandom_range(0, 3) == 0) ? pick_value() : 8'hFF,
                                       LABEL_W'($urandom));
        settle_block();
        cfg_write(REG_FRAME_WIDTH, 13'h0010);
        put_pixel(8'hFF, LABEL_W'($urandom));
        setup_frame(1, 13'h1000, 13'h0000, {11'h000, MODE_PIXELS});
        repeat (EXTREME_RUN) put_pixel(($urandom_range(0, 3) == 0) ? pick_value() : 8'hFF,
                                       LABEL_W'($urandom));
        settle_block();
        cfg_write(REG_FRAME_HEIGHT, 13'h0010);
        put_pixel(8'hFF, LABEL_W'($urandom));
    endtask

    task automatic test_random_frames();
        int                    sent;
        int                    total;
        int                    split;
        int                    we;
        int                    he;
        int                    r;
        logic [CFG_DATA_W-1:0] wd;
        logic [CFG_DATA_W-1:0] hd;
        logic [CFG_DATA_W-1:0] ld;
        t_reg                  resize_reg;
        sent = 0;
        while (sent < RANDOM_PIXELS) begin
            r  = $urandom_range(0, 99);
            wd = CFG_DATA_W'((r < 5) ? 0 : (r < 10) ? $urandom_range(9, 40)
                                                    : $urandom_range(1, 8));
            hd = CFG_DATA_W'(($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 6));
            ld = CFG_DATA_W'($urandom_range(0, 8191));
            setup_frame(wd, hd, ld, CFG_DATA_W'($urandom_range(0, 8191)));
            gap_max   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            r         = $urandom_range(0, 2);
            stall_pct = (r == 0) ? 0 : (r == 1) ? 25 : 60;
            we    = (wd == 0) ? 1 : wd;
            he    = (hd == 0) ? 1 : hd;
            total = ((we > 8) ? 1 : $urandom_range(1, 4)) * we * he;
            split = ($urandom_range(0, 5) == 0) ? $urandom_range(1, total) : total;
            for (int k = 0; k < total; k++) begin
                if (k == split) begin
                    settle_block();
                    resize_reg = ($urandom_range(0, 1) == 0) ? REG_FRAME_WIDTH
                                                             : REG_FRAME_HEIGHT;
                    cfg_write(resize_reg, CFG_DATA_W'($urandom_range(1, 8)));
                end
                put_pixel(pick_value(),
                          ($urandom_range(0, 1) == 0) ? ld[LABEL_W-1:0] : LABEL_W'($urandom));
            end
            sent += total;
        end
    endtask

    initial begin
        t_moments lost;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_source_modes();
        test_empty_frame_size();
        test_mid_frame_resize();
        test_back_pressure();
        test_extreme_frames();
        test_random_frames();
        i_in_valid <= 1'b0;
        for (int c = 0; c < 20000 && pending_moments.size() != 0; c++) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (pending_moments.size() != 0) begin
            lost = pending_moments.pop_front();
            report_mismatch("word never returned, pixel_count", 0, lost.count);
        end
        if (fails == 0) begin
            $display("image_raw_moments_accumulator: match");
        end else begin
            $display("image_raw_moments_accumulator: mismatch");
        end
        $finish;
    end

endmodule
